// ----- rtl/core/usb_host_controller_registers_defines.svh -----
// assertion macros used by the register file checker
`ifndef USB_HOST_CONTROLLER_REGISTERS_DEFINES_SVH
`define USB_HOST_CONTROLLER_REGISTERS_DEFINES_SVH

// same-cycle implication, disabled while reset is low
`define UHCR_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while reset is low
`define UHCR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/uhcr_pkg.sv -----
// types and constants of the host controller register file
package uhcr_pkg;

	// number of root ports
	localparam int unsigned NUM_PORTS = 2;
	// width of the internal reset pulse vector, at least the port field width
	localparam int unsigned PULSE_W = (NUM_PORTS > 2) ? NUM_PORTS : 2;

	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned IN_TUSER_W  = 3;
	localparam int unsigned OUT_TDATA_W = 72;

	// operation codes carried on the input tuser
	typedef enum logic [2:0] {
		OP_READ_WORD  = 3'd0,
		OP_READ_BYTE  = 3'd1,
		OP_WRITE_BYTE = 3'd2,
		OP_WRITE_WORD = 3'd3,
		OP_FRAME_TICK = 3'd4,
		OP_ATTACH     = 3'd5,
		OP_DETACH     = 3'd6
	} op_t;

	// register byte offsets
	localparam logic [4:0] ADDR_CMD      = 5'h00;
	localparam logic [4:0] ADDR_STS      = 5'h02;
	localparam logic [4:0] ADDR_INTR     = 5'h04;
	localparam logic [4:0] ADDR_FRNUM    = 5'h06;
	localparam logic [4:0] ADDR_FLBASE_L = 5'h08;
	localparam logic [4:0] ADDR_FLBASE_1 = 5'h09;
	localparam logic [4:0] ADDR_FLBASE_H = 5'h0a;
	localparam logic [4:0] ADDR_FLBASE_3 = 5'h0b;
	localparam logic [4:0] ADDR_SOF      = 5'h0c;

	// command bits
	localparam int unsigned CMD_RS      = 0;
	localparam int unsigned CMD_HCRESET = 1;
	localparam int unsigned CMD_GRESET  = 2;
	localparam int unsigned CMD_EGSM    = 3;
	localparam int unsigned CMD_FGR     = 4;

	// status bits
	localparam int unsigned STS_INT   = 0;
	localparam int unsigned STS_ERR   = 1;
	localparam int unsigned STS_RD    = 2;
	localparam int unsigned STS_HSERR = 3;
	localparam int unsigned STS_PERR  = 4;
	localparam int unsigned STS_HALT  = 5;

	// port status and control bits
	localparam int unsigned PORT_CCS = 0;
	localparam int unsigned PORT_CSC = 1;
	localparam int unsigned PORT_EN  = 2;
	localparam int unsigned PORT_ENC = 3;
	localparam int unsigned PORT_RST = 9;

	localparam logic [15:0] PORT_RO_MASK  = 16'h01bb;
	localparam logic [15:0] PORT_CHG_MASK = 16'h000a;
	localparam logic [15:0] PORT_IDLE     = 16'h0080;
	localparam logic [15:0] PORT_PRESENT  = 16'h0083;
	localparam logic [15:0] UNUSED_READ   = 16'hff7f;
	localparam logic [15:0] STS_RESET     = 16'h0020;
	localparam logic [15:0] HIGH_BYTE     = 16'hff00;
	localparam logic [7:0]  SOF_RESET     = 8'd64;
	localparam logic [13:0] PERIOD_BASE   = 14'd11936;
	localparam logic [10:0] FRNUM_MASK    = 11'h7ff;

	// one accepted input word
	typedef struct packed {
		logic       tick_process_error;
		logic       tick_usb_error;
		logic [1:0] tick_int_mask;
		logic       port_index;
		logic [15:0] write_data;
		logic [4:0] address;
		op_t        operation;
	} item_t;

	// one result word, last field in the lowest bits
	typedef struct packed {
		logic [1:0]  device_reset_mask;
		logic [31:0] frame_list_address;
		logic [13:0] frame_period_bits;
		logic        frame_timer_running;
		logic        irq_level;
		logic [15:0] read_data;
	} result_t;

endpackage

// ----- rtl/core/uhcr_regfile.sv -----
// register state and update logic of the host controller
module uhcr_regfile (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  uhcr_pkg::item_t  item,
	output uhcr_pkg::result_t result
);
	import uhcr_pkg::*;

	logic [15:0] cmd_q, cmd_n;
	logic [15:0] sts_q, sts_n;
	logic [1:0]  cause_q, cause_n;
	logic [15:0] intr_q, intr_n;
	logic [10:0] frnum_q, frnum_n;
	logic [31:0] flbase_q, flbase_n;
	logic [7:0]  sof_q, sof_n;
	logic [15:0] port_q [NUM_PORTS];
	logic [15:0] port_n [NUM_PORTS];
	logic [NUM_PORTS-1:0] present_q, present_n;
	logic        timer_q, timer_n;

	logic [4:0]  rd_addr;
	logic [15:0] rd_word;
	logic [PULSE_W-1:0] present_mask;

	// present devices as a pulse-wide vector
	always_comb begin
		present_mask = '0;
		present_mask[NUM_PORTS-1:0] = present_q;
	end

	// register read, byte reads use the even word
	assign rd_addr = (item.operation == OP_READ_BYTE) ? {item.address[4:1], 1'b0} : item.address;

	always_comb begin
		rd_word = UNUSED_READ;
		case (rd_addr)
			ADDR_CMD:      rd_word = cmd_q;
			ADDR_STS:      rd_word = sts_q;
			ADDR_INTR:     rd_word = intr_q;
			ADDR_FRNUM:    rd_word = {5'd0, frnum_q};
			ADDR_FLBASE_L: rd_word = flbase_q[15:0];
			ADDR_FLBASE_H: rd_word = flbase_q[31:16];
			ADDR_SOF:      rd_word = {8'd0, sof_q};
			default: begin
				for (int i = 0; i < NUM_PORTS; i++) begin
					if (rd_addr[4] && !rd_addr[0] && rd_addr[3:1] == 3'(i)) begin
						rd_word = port_q[i];
					end
				end
			end
		endcase
	end

	// next state and result for the word in the input stage
	always_comb begin
		logic [15:0] wv;
		logic [15:0] pc;
		logic [15:0] pv;
		logic        is_byte;
		logic        is_write;
		logic        do_reset;
		logic        resume;
		logic [PULSE_W-1:0] pulses;
		logic [15:0] rd;

		cmd_n     = cmd_q;
		sts_n     = sts_q;
		cause_n   = cause_q;
		intr_n    = intr_q;
		frnum_n   = frnum_q;
		flbase_n  = flbase_q;
		sof_n     = sof_q;
		present_n = present_q;
		timer_n   = timer_q;
		for (int i = 0; i < NUM_PORTS; i++) begin
			port_n[i] = port_q[i];
		end
		is_byte  = (item.operation == OP_WRITE_BYTE);
		is_write = is_byte || (item.operation == OP_WRITE_WORD);
		wv       = is_byte ? {8'd0, item.write_data[7:0]} : item.write_data;
		do_reset = 1'b0;
		resume   = 1'b0;
		pulses   = '0;
		rd       = '0;
		pc       = '0;
		pv       = '0;

		case (item.operation)
			OP_READ_WORD: rd = rd_word;
			OP_READ_BYTE: rd = item.address[0] ? {8'd0, rd_word[15:8]} : {8'd0, rd_word[7:0]};
			OP_WRITE_BYTE, OP_WRITE_WORD: begin
				case (item.address)
					ADDR_CMD: begin
						// run/stop edge handling
						if (wv[CMD_RS] && !cmd_q[CMD_RS]) begin
							timer_n = 1'b1;
							sts_n[STS_HALT] = 1'b0;
						end else if (!wv[CMD_RS]) begin
							timer_n = 1'b0;
							sts_n[STS_HALT] = 1'b1;
						end
						if (wv[CMD_GRESET] || wv[CMD_HCRESET]) begin
							do_reset = 1'b1;
						end else begin
							cmd_n = is_byte ? {cmd_q[15:8], wv[7:0]} : wv;
						end
					end
					ADDR_STS: begin
						// write one to clear
						sts_n = is_byte ? (sts_q & (~wv | HIGH_BYTE)) : (sts_q & ~wv);
						if (wv[STS_INT]) begin
							cause_n = 2'd0;
						end
					end
					ADDR_INTR: intr_n = is_byte ? {intr_q[15:8], wv[7:0]} : wv;
					ADDR_FRNUM: begin
						if (!is_byte && sts_q[STS_HALT]) begin
							frnum_n = wv[10:0] & FRNUM_MASK;
						end
					end
					ADDR_FLBASE_L: begin
						if (!is_byte) begin
							flbase_n[15:0] = {wv[15:12], 12'd0};
						end
					end
					ADDR_FLBASE_1: begin
						if (is_byte) begin
							flbase_n[15:0] = {wv[7:4], 12'd0};
						end
					end
					ADDR_FLBASE_H: begin
						if (is_byte) begin
							flbase_n[23:16] = wv[7:0];
						end else begin
							flbase_n[31:16] = wv;
						end
					end
					ADDR_FLBASE_3: begin
						if (is_byte) begin
							flbase_n[31:24] = wv[7:0];
						end
					end
					ADDR_SOF: sof_n = wv[7:0];
					default: begin
						// port registers take word writes only
						for (int i = 0; i < NUM_PORTS; i++) begin
							if (!is_byte && item.address[4] && !item.address[0] &&
									item.address[3:1] == 3'(i)) begin
								if (present_q[i] && wv[PORT_RST] && !port_q[i][PORT_RST]) begin
									pulses[i] = 1'b1;
								end
								pc = port_q[i] & PORT_RO_MASK;
								pv = wv;
								if (!pc[PORT_CCS]) begin
									pv[PORT_EN] = 1'b0;
								end
								pc = pc | (pv & ~PORT_RO_MASK);
								pc = pc & ~(pv & PORT_CHG_MASK);
								port_n[i] = pc;
							end
						end
					end
				endcase
			end
			OP_FRAME_TICK: begin
				if (timer_q) begin
					if (!cmd_q[CMD_RS]) begin
						timer_n = 1'b0;
						sts_n[STS_HALT] = 1'b1;
					end else begin
						if (item.tick_usb_error) begin
							sts_n[STS_ERR] = 1'b1;
						end
						if (item.tick_process_error) begin
							sts_n[STS_PERR] = 1'b1;
							cmd_n[CMD_RS] = 1'b0;
						end
						frnum_n = (frnum_q + 11'd1) & FRNUM_MASK;
						if (item.tick_int_mask != 2'd0) begin
							cause_n = cause_q | item.tick_int_mask;
							sts_n[STS_INT] = 1'b1;
						end
					end
				end
			end
			OP_ATTACH: begin
				for (int i = 0; i < NUM_PORTS; i++) begin
					if (3'(i) == {2'd0, item.port_index}) begin
						port_n[i][PORT_CCS] = 1'b1;
						port_n[i][PORT_CSC] = 1'b1;
						present_n[i] = 1'b1;
						resume = 1'b1;
					end
				end
			end
			OP_DETACH: begin
				for (int i = 0; i < NUM_PORTS; i++) begin
					if (3'(i) == {2'd0, item.port_index}) begin
						if (port_q[i][PORT_CCS]) begin
							port_n[i][PORT_CCS] = 1'b0;
							port_n[i][PORT_CSC] = 1'b1;
						end
						if (port_q[i][PORT_EN]) begin
							port_n[i][PORT_EN] = 1'b0;
							port_n[i][PORT_ENC] = 1'b1;
						end
						present_n[i] = 1'b0;
						resume = 1'b1;
					end
				end
			end
			default: ;
		endcase

		// resume signalling while in global suspend
		if (resume && cmd_q[CMD_EGSM]) begin
			cmd_n[CMD_FGR] = 1'b1;
			sts_n[STS_RD]  = 1'b1;
		end

		// host or global reset of the controller
		if (is_write && do_reset) begin
			cmd_n    = '0;
			sts_n    = STS_RESET;
			cause_n  = 2'd0;
			intr_n   = '0;
			flbase_n = '0;
			sof_n    = SOF_RESET;
			for (int i = 0; i < NUM_PORTS; i++) begin
				port_n[i] = present_q[i] ? PORT_PRESENT : PORT_IDLE;
			end
			pulses = pulses | present_mask;
		end

		// result from the updated state
		result.read_data = rd;
		result.irq_level = (cause_n[0] && intr_n[2]) || (cause_n[1] && intr_n[3]) ||
			(sts_n[STS_ERR] && intr_n[0]) || (sts_n[STS_RD] && intr_n[1]) ||
			sts_n[STS_HSERR] || sts_n[STS_PERR];
		result.frame_timer_running = timer_n;
		result.frame_period_bits   = PERIOD_BASE + {6'd0, sof_n};
		result.frame_list_address  = {flbase_n[31:12], frnum_n[9:0], 2'b00};
		result.device_reset_mask   = pulses[1:0];
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_q     <= '0;
			sts_q     <= STS_RESET;
			cause_q   <= 2'd0;
			intr_q    <= '0;
			frnum_q   <= '0;
			flbase_q  <= '0;
			sof_q     <= SOF_RESET;
			present_q <= '0;
			timer_q   <= 1'b0;
			for (int i = 0; i < NUM_PORTS; i++) begin
				port_q[i] <= PORT_IDLE;
			end
		end else if (step) begin
			cmd_q     <= cmd_n;
			sts_q     <= sts_n;
			cause_q   <= cause_n;
			intr_q    <= intr_n;
			frnum_q   <= frnum_n;
			flbase_q  <= flbase_n;
			sof_q     <= sof_n;
			present_q <= present_n;
			timer_q   <= timer_n;
			for (int i = 0; i < NUM_PORTS; i++) begin
				port_q[i] <= port_n[i];
			end
		end
	end

endmodule

// ----- rtl/core/usb_host_controller_registers.sv -----
// a word accepted into the input stage moves on to the result register, which drives the output
// throughput: one word per cycle while the sink keeps taking results, set by the register update logic
// an input stage and a result register part the two sides, so input is taken
// while a finished result waits for the sink
// reset: asynchronous, active low; registers take their power-on values,
// frame number zero and all ports idle with no device present
module usb_host_controller_registers (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	// address, write_data, port_index, tick_int_mask, tick_usb_error,
	// tick_process_error, zero fill
	input  logic [uhcr_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
	// operation
	input  logic [uhcr_pkg::IN_TUSER_W-1:0]   s_axis_tuser,
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	// read_data, irq_level, frame_timer_running, frame_period_bits,
	// frame_list_address, device_reset_mask, zero fill
	output logic [uhcr_pkg::OUT_TDATA_W-1:0]  m_axis_tdata
);
	import uhcr_pkg::*;

	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t result_s2;
	result_t result;
	logic    advance;
	logic    accept;

	// the input stage moves on when the result register is free or being emptied
	assign advance       = valid_s1 && (!valid_s2 || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign accept        = s_axis_tvalid && s_axis_tready;

	// input stage control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1.operation          <= op_t'(s_axis_tuser);
			item_s1.address            <= s_axis_tdata[4:0];
			item_s1.write_data         <= s_axis_tdata[20:5];
			item_s1.port_index         <= s_axis_tdata[21];
			item_s1.tick_int_mask      <= s_axis_tdata[23:22];
			item_s1.tick_usb_error     <= s_axis_tdata[24];
			item_s1.tick_process_error <= s_axis_tdata[25];
		end
	end

	uhcr_regfile u_regfile (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.result (result)
	);

	// result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_axis_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	// result register payload
	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= result;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tdata  = {(OUT_TDATA_W - $bits(result_t))'(0), result_s2};

endmodule

// ----- rtl/core/uhcr_checker.sv -----
// port-level checks of the register file, bound to the top level
`include "usb_host_controller_registers_defines.svh"

module uhcr_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             s_axis_tready,
	input logic                             m_axis_tvalid,
	input logic                             m_axis_tready,
	input logic [uhcr_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
	import uhcr_pkg::*;

	// a stalled result word holds
	`UHCR_ASSERT_NEXT(a_out_hold, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result word changed")

	// with the result register empty the input side is always open
	`UHCR_ASSERT_NOW(a_ready_when_empty, clk, arst_n, !m_axis_tvalid, s_axis_tready, "input stalled with empty result register")

	// frame period stays inside base plus one byte of timing
	`UHCR_ASSERT_NOW(a_period_range, clk, arst_n, m_axis_tvalid, (m_axis_tdata[31:18] >= PERIOD_BASE) && (m_axis_tdata[31:18] <= PERIOD_BASE + 14'd255), "frame period out of range")

	// frame list entries are word aligned and the fill is zero
	`UHCR_ASSERT_NOW(a_list_aligned, clk, arst_n, m_axis_tvalid, (m_axis_tdata[33:32] == 2'b00) && (m_axis_tdata[71:66] == 6'd0), "misaligned frame list address or dirty fill")

endmodule

bind usb_host_controller_registers uhcr_checker u_uhcr_checker (.*);

// ----- bench/tb_usb_host_controller_registers.sv -----
// self-checking bench for the host controller register file, directed rows then random traffic
module tb_usb_host_controller_registers;
	timeunit 1ns;
	timeprecision 1ps;

	import uhcr_pkg::*;

	// operation code with no meaning, must leave every register alone
	localparam logic [2:0] OP_UNUSED  = 3'd7;
	localparam logic [4:0] ADDR_PORT0 = 5'h10;
	localparam logic [4:0] ADDR_PORT1 = 5'h12;
	localparam int HOLD_CYCLES  = 60;
	localparam int PHASE_WORDS  = 160;
	localparam int SETTLE_CYCLES = 8;

	// one bus access or event as the bench sees it
	typedef struct packed {
		logic [2:0]  op;
		logic [4:0]  addr;
		logic [15:0] wdata;
		logic        port;
		logic [1:0]  mask;
		logic        uerr;
		logic        perr;
	} bus_word_t;

	// directed row, read data typed in where it is plain
	typedef struct packed {
		bus_word_t   w;
		logic        known;
		logic [15:0] rd;
	} directed_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
	logic [IN_TUSER_W-1:0] s_axis_tuser = '0;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;

	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_requests = 0;
	int hold_served = 0;
	int mismatches = 0;

	result_t pending_results[$];
	directed_row_t directed_rows[$];
	result_t mon_got;
	result_t mon_want;

	// predicted register contents
	logic [15:0] hc_cmd;
	logic [15:0] hc_sts;
	logic [15:0] hc_ien;
	logic [1:0]  hc_cause;
	logic [10:0] hc_frnum;
	logic [31:0] hc_base;
	logic [7:0]  hc_sof;
	logic [15:0] hc_portsc [NUM_PORTS];
	logic        hc_present [NUM_PORTS];
	logic        hc_timer;

	usb_host_controller_registers dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	always #5 clk = ~clk;

	// ports with a device attached
	function automatic logic [7:0] present_ports();
		logic [7:0] m;
		m = '0;
		for (int i = 0; i < NUM_PORTS; i++)
			if (hc_present[i])
				m[i] = 1'b1;
		return m;
	endfunction

	// host or global reset: frame number and timer survive
	function automatic logic [7:0] controller_reset();
		hc_cmd = '0;
		hc_sts = STS_RESET;
		hc_cause = '0;
		hc_ien = '0;
		hc_base = '0;
		hc_sof = SOF_RESET;
		for (int i = 0; i < NUM_PORTS; i++)
			hc_portsc[i] = hc_present[i] ? PORT_PRESENT : PORT_IDLE;
		return present_ports();
	endfunction

	function automatic void power_on();
		logic [7:0] unused_pulses;
		for (int i = 0; i < NUM_PORTS; i++)
			hc_present[i] = 1'b0;
		hc_frnum = '0;
		hc_timer = 1'b0;
		unused_pulses = controller_reset();
	endfunction

	function automatic logic irq_now();
		return (hc_cause[0] && hc_ien[2]) || (hc_cause[1] && hc_ien[3]) ||
			(hc_sts[STS_ERR] && hc_ien[0]) || (hc_sts[STS_RD] && hc_ien[1]) ||
			hc_sts[STS_HSERR] || hc_sts[STS_PERR];
	endfunction

	// attach or detach while global suspend is on wakes the bus
	function automatic void resume_event();
		if (hc_cmd[CMD_EGSM]) begin
			hc_cmd[CMD_FGR] = 1'b1;
			hc_sts[STS_RD] = 1'b1;
		end
	endfunction

	function automatic logic [15:0] read_reg(logic [4:0] a);
		case (a)
			ADDR_CMD:      return hc_cmd;
			ADDR_STS:      return hc_sts;
			ADDR_INTR:     return hc_ien;
			ADDR_FRNUM:    return {5'b0, hc_frnum};
			ADDR_FLBASE_L: return hc_base[15:0];
			ADDR_FLBASE_H: return hc_base[31:16];
			ADDR_SOF:      return {8'b0, hc_sof};
			default: ;
		endcase
		if (a >= ADDR_PORT0 && !a[0] && int'(a[3:1]) < NUM_PORTS)
			return hc_portsc[a[3:1]];
		return UNUSED_READ;
	endfunction

	// run/stop and resets, shared by byte and word command writes
	function automatic logic command_write(logic [15:0] v, inout logic [7:0] pulses);
		if (v[CMD_RS] && !hc_cmd[CMD_RS]) begin
			hc_timer = 1'b1;
			hc_sts[STS_HALT] = 1'b0;
		end else if (!v[CMD_RS]) begin
			hc_timer = 1'b0;
			hc_sts[STS_HALT] = 1'b1;
		end
		if (v[CMD_GRESET]) begin
			pulses |= present_ports();
			pulses |= controller_reset();
			return 1'b1;
		end
		if (v[CMD_HCRESET]) begin
			pulses |= controller_reset();
			return 1'b1;
		end
		return 1'b0;
	endfunction

	function automatic void write_byte(logic [4:0] a, logic [7:0] v, inout logic [7:0] pulses);
		case (a)
			ADDR_CMD: begin
				if (!command_write({8'b0, v}, pulses))
					hc_cmd[7:0] = v;
			end
			ADDR_STS: begin
				hc_sts[7:0] = hc_sts[7:0] & ~v;
				if (v[STS_INT])
					hc_cause = '0;
			end
			ADDR_INTR:     hc_ien[7:0] = v;
			ADDR_FLBASE_1: hc_base[15:0] = {v[7:4], 12'b0};
			ADDR_FLBASE_H: hc_base[23:16] = v;
			ADDR_FLBASE_3: hc_base[31:24] = v;
			ADDR_SOF:      hc_sof = v;
			default: ;
		endcase
	endfunction

	function automatic void write_port(int n, logic [15:0] v, inout logic [7:0] pulses);
		logic [15:0] c;
		c = hc_portsc[n];
		if (hc_present[n] && v[PORT_RST] && !c[PORT_RST])
			pulses[n] = 1'b1;
		c &= PORT_RO_MASK;
		if (!c[PORT_CCS])
			v[PORT_EN] = 1'b0;
		c |= v & ~PORT_RO_MASK;
		c &= ~(v & PORT_CHG_MASK);
		hc_portsc[n] = c;
	endfunction

	function automatic void write_word(logic [4:0] a, logic [15:0] v, inout logic [7:0] pulses);
		case (a)
			ADDR_CMD: begin
				if (!command_write(v, pulses))
					hc_cmd = v;
			end
			ADDR_STS: begin
				hc_sts &= ~v;
				if (v[STS_INT])
					hc_cause = '0;
			end
			ADDR_INTR: hc_ien = v;
			ADDR_FRNUM: begin
				if (hc_sts[STS_HALT])
					hc_frnum = v[10:0];
			end
			ADDR_FLBASE_L: hc_base[15:0] = {v[15:12], 12'b0};
			ADDR_FLBASE_H: hc_base[31:16] = v;
			ADDR_SOF:      hc_sof = v[7:0];
			default: begin
				if (a >= ADDR_PORT0 && !a[0] && int'(a[3:1]) < NUM_PORTS)
					write_port(int'(a[3:1]), v, pulses);
			end
		endcase
	endfunction

	function automatic void frame_tick(logic [1:0] mask, logic uerr, logic perr);
		if (!hc_timer)
			return;
		// run cleared: timer stops at this frame boundary
		if (!hc_cmd[CMD_RS]) begin
			hc_timer = 1'b0;
			hc_sts[STS_HALT] = 1'b1;
			return;
		end
		if (uerr)
			hc_sts[STS_ERR] = 1'b1;
		if (perr) begin
			hc_sts[STS_PERR] = 1'b1;
			hc_cmd[CMD_RS] = 1'b0;
		end
		hc_frnum = hc_frnum + 11'd1;
		if (mask != 2'b00) begin
			hc_cause |= mask;
			hc_sts[STS_INT] = 1'b1;
		end
	endfunction

	// next state and result word for one accepted access or event
	function automatic result_t regfile_step(bus_word_t w);
		result_t r;
		logic [7:0] pulses;
		logic [15:0] rd;
		pulses = '0;
		rd = '0;
		case (w.op)
			OP_READ_WORD: rd = read_reg(w.addr);
			OP_READ_BYTE: begin
				rd = read_reg({w.addr[4:1], 1'b0});
				if (w.addr[0])
					rd = rd >> 8;
				rd &= 16'h00ff;
			end
			OP_WRITE_BYTE: write_byte(w.addr, w.wdata[7:0], pulses);
			OP_WRITE_WORD: write_word(w.addr, w.wdata, pulses);
			OP_FRAME_TICK: frame_tick(w.mask, w.uerr, w.perr);
			OP_ATTACH: begin
				if (int'(w.port) < NUM_PORTS) begin
					hc_portsc[w.port][PORT_CCS] = 1'b1;
					hc_portsc[w.port][PORT_CSC] = 1'b1;
					hc_present[w.port] = 1'b1;
					resume_event();
				end
			end
			OP_DETACH: begin
				if (int'(w.port) < NUM_PORTS) begin
					if (hc_portsc[w.port][PORT_CCS]) begin
						hc_portsc[w.port][PORT_CCS] = 1'b0;
						hc_portsc[w.port][PORT_CSC] = 1'b1;
					end
					if (hc_portsc[w.port][PORT_EN]) begin
						hc_portsc[w.port][PORT_EN] = 1'b0;
						hc_portsc[w.port][PORT_ENC] = 1'b1;
					end
					hc_present[w.port] = 1'b0;
					resume_event();
				end
			end
			default: ;
		endcase
		r.read_data = rd;
		r.irq_level = irq_now();
		r.frame_timer_running = hc_timer;
		r.frame_period_bits = PERIOD_BASE + {6'b0, hc_sof};
		r.frame_list_address = {hc_base[31:12], hc_frnum[9:0], 2'b00};
		r.device_reset_mask = pulses[1:0];
		return r;
	endfunction

	function automatic void add_row(logic [2:0] op, logic [4:0] addr, logic [15:0] wdata,
			logic port, logic [1:0] mask, logic uerr, logic perr, logic known, logic [15:0] rd);
		directed_row_t row;
		row.w.op = op;
		row.w.addr = addr;
		row.w.wdata = wdata;
		row.w.port = port;
		row.w.mask = mask;
		row.w.uerr = uerr;
		row.w.perr = perr;
		row.known = known;
		row.rd = rd;
		directed_rows.push_back(row);
	endfunction

	// mostly real register offsets, command writes kept mostly free of resets
	function automatic bus_word_t random_word();
		bus_word_t w;
		logic [4:0] offsets [11];
		int k;
		offsets = '{ADDR_CMD, ADDR_STS, ADDR_INTR, ADDR_FRNUM, ADDR_FLBASE_L, ADDR_FLBASE_1,
			ADDR_FLBASE_H, ADDR_FLBASE_3, ADDR_SOF, ADDR_PORT0, ADDR_PORT1};
		w.wdata = 16'($urandom);
		w.port = 1'($urandom);
		w.mask = 2'($urandom);
		w.uerr = ($urandom_range(3) == 0);
		w.perr = ($urandom_range(9) == 0);
		w.addr = ($urandom_range(9) < 8) ? offsets[$urandom_range(10)] : 5'($urandom);
		k = $urandom_range(99);
		if (k < 18)
			w.op = OP_READ_WORD;
		else if (k < 30)
			w.op = OP_READ_BYTE;
		else if (k < 45)
			w.op = OP_WRITE_BYTE;
		else if (k < 70)
			w.op = OP_WRITE_WORD;
		else if (k < 90)
			w.op = OP_FRAME_TICK;
		else if (k < 94)
			w.op = OP_ATTACH;
		else if (k < 98)
			w.op = OP_DETACH;
		else
			w.op = OP_UNUSED;
		if (w.addr == ADDR_CMD && (w.op == OP_WRITE_WORD || w.op == OP_WRITE_BYTE)) begin
			if ($urandom_range(9) != 0) begin
				w.wdata[CMD_HCRESET] = 1'b0;
				w.wdata[CMD_GRESET] = 1'b0;
			end
			w.wdata[CMD_RS] = ($urandom_range(3) != 0);
		end
		return w;
	endfunction

	// offer one word, predict on acceptance
	task automatic send_word(bus_word_t w, logic known, logic [15:0] rd);
		result_t r;
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser = w.op;
		s_axis_tdata = {6'b0, w.perr, w.uerr, w.mask, w.port, w.wdata, w.addr};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		r = regfile_step(w);
		if (known)
			r.read_data = rd;
		pending_results.push_back(r);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		while (pending_results.size() != 0)
			@(negedge clk);
	endtask

	task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// sink side: random stalls plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_served != hold_requests) begin
				hold_served++;
				m_axis_tready = 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
			end
			m_axis_tready = (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// compare each result word with the oldest prediction
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			mon_got = m_axis_tdata[$bits(result_t)-1:0];
			if (pending_results.size() == 0) begin
				$display("%0t: result word with nothing expected, got 0x%0h", $time, mon_got);
				mismatches++;
			end else begin
				mon_want = pending_results.pop_front();
				check_field("read_data", mon_want.read_data, mon_got.read_data);
				check_field("irq_level", mon_want.irq_level, mon_got.irq_level);
				check_field("frame_timer_running", mon_want.frame_timer_running,
					mon_got.frame_timer_running);
				check_field("frame_period_bits", mon_want.frame_period_bits,
					mon_got.frame_period_bits);
				check_field("frame_list_address", mon_want.frame_list_address,
					mon_got.frame_list_address);
				check_field("device_reset_mask", mon_want.device_reset_mask,
					mon_got.device_reset_mask);
			end
		end
	end

	// stimulus
	initial begin
		power_on();
		// reset values, unused offsets, extremes, every operation
		add_row(OP_READ_WORD,  ADDR_CMD,      16'h0000, 0, 0, 0, 0, 1, 16'h0000);
		add_row(OP_READ_WORD,  ADDR_STS,      16'h0000, 0, 0, 0, 0, 1, STS_RESET);
		// port beyond the last one, then an odd word offset
		add_row(OP_READ_WORD,  5'h14,         16'h0000, 0, 0, 0, 0, 1, UNUSED_READ);
		add_row(OP_READ_WORD,  5'h11,         16'h0000, 0, 0, 0, 0, 1, UNUSED_READ);
		add_row(OP_READ_BYTE,  5'h03,         16'h0000, 0, 0, 0, 0, 1, 16'h0000);
		add_row(OP_READ_BYTE,  5'h1f,         16'h0000, 0, 0, 0, 0, 1, 16'h00ff);
		add_row(OP_WRITE_WORD, ADDR_FRNUM,    16'hffff, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_READ_WORD,  ADDR_FRNUM,    16'h0000, 0, 0, 0, 0, 1, 16'h07ff);
		add_row(OP_WRITE_WORD, ADDR_FLBASE_H, 16'hffff, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_WRITE_BYTE, ADDR_FLBASE_1, 16'hffff, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_WRITE_WORD, ADDR_SOF,      16'hffff, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_READ_WORD,  ADDR_SOF,      16'h0000, 0, 0, 0, 0, 1, 16'h00ff);
		add_row(OP_WRITE_WORD, ADDR_INTR,     16'h000f, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_ATTACH,     ADDR_CMD,      16'h0000, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_ATTACH,     ADDR_CMD,      16'h0000, 1, 0, 0, 0, 0, 16'h0000);
		// port reset with enable: one device reset pulse
		add_row(OP_WRITE_WORD, ADDR_PORT0,    16'h0204, 0, 0, 0, 0, 0, 16'h0000);
		// run with global suspend enabled
		add_row(OP_WRITE_WORD, ADDR_CMD,      16'h0009, 0, 0, 0, 0, 0, 16'h0000);
		// frame number is locked while running
		add_row(OP_WRITE_WORD, ADDR_FRNUM,    16'h0000, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_FRAME_TICK, ADDR_CMD,      16'h0000, 0, 3, 1, 0, 0, 16'h0000);
		add_row(OP_FRAME_TICK, ADDR_CMD,      16'h0000, 0, 0, 0, 1, 0, 16'h0000);
		// run now clear: halts, then a tick on a stopped timer does nothing
		add_row(OP_FRAME_TICK, ADDR_CMD,      16'h0000, 0, 3, 1, 1, 0, 16'h0000);
		add_row(OP_FRAME_TICK, ADDR_CMD,      16'h0000, 0, 3, 1, 1, 0, 16'h0000);
		add_row(OP_DETACH,     ADDR_CMD,      16'h0000, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_WRITE_BYTE, ADDR_STS,      16'h00ff, 0, 0, 0, 0, 0, 16'h0000);
		// global reset, then host reset
		add_row(OP_WRITE_WORD, ADDR_CMD,      16'h0004, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_READ_WORD,  ADDR_PORT1,    16'h0000, 0, 0, 0, 0, 1, PORT_PRESENT);
		add_row(OP_WRITE_WORD, ADDR_CMD,      16'h0002, 0, 0, 0, 0, 0, 16'h0000);
		add_row(OP_UNUSED,     ADDR_CMD,      16'hffff, 1, 3, 1, 1, 0, 16'h0000);

		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		foreach (directed_rows[i])
			send_word(directed_rows[i].w, directed_rows[i].known, directed_rows[i].rd);
		s_axis_tvalid = 1'b0;
		wait_drained();

		// random traffic under four idling patterns, draining between them
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
				1: begin send_idle_pct = 66; recv_stall_pct = 0;  end
				2: begin send_idle_pct = 0;  recv_stall_pct = 66; end
				default: begin send_idle_pct = 6; recv_stall_pct = 6; end
			endcase
			for (int i = 0; i < PHASE_WORDS; i++) begin
				// long sink hold-off while words keep coming
				if (ph == 0 && i == PHASE_WORDS / 2)
					hold_requests++;
				send_word(random_word(), 1'b0, 16'h0000);
			end
			s_axis_tvalid = 1'b0;
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(negedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// watchdog
	initial begin
		#3_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ----- filelist.f -----
+incdir+rtl/core
rtl/core/uhcr_pkg.sv
rtl/core/uhcr_regfile.sv
rtl/core/usb_host_controller_registers.sv
rtl/core/uhcr_checker.sv
bench/tb_usb_host_controller_registers.sv
